>>> rtl/imar_pkg.sv
// ----------------------------------------------------------------------------
// imar_pkg
// Shared widths, register codes and scale coefficients for the IMU moving
// average and rotate block.
// ----------------------------------------------------------------------------
package imar_pkg;

   // window depths, in samples
   localparam int ACCEL_DEPTH = 8;
   localparam int RATE_DEPTH  = 8;

   localparam int IN_W       = 16;
   localparam int OUT_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int LANES      = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GYRO_OFFSET_X = 2'd0,
      CSR_GYRO_OFFSET_Y = 2'd1,
      CSR_GYRO_OFFSET_Z = 2'd2
   } imar_csr_type;

   // output lanes
   localparam int LANE_ACC_X  = 0;
   localparam int LANE_ACC_Y  = 1;
   localparam int LANE_ACC_Z  = 2;
   localparam int LANE_RATE_X = 3;
   localparam int LANE_RATE_Y = 4;
   localparam int LANE_RATE_Z = 5;

   // running sums hold exact window totals
   localparam int ACCEL_SUM_W = IN_W + $clog2(ACCEL_DEPTH);
   localparam int RATE_SUM_W  = IN_W + $clog2(RATE_DEPTH);
   localparam int MAX_SUM_W   = (ACCEL_SUM_W > RATE_SUM_W) ? ACCEL_SUM_W : RATE_SUM_W;
   // sum or difference of two sums, and its magnitude
   localparam int MAG_W       = MAX_SUM_W + 1;

   // exact rational scale per lane: numerator / denominator
   localparam logic [127:0] DEN_ACC_XY  = 128'd781250000 * 128'(ACCEL_DEPTH);
   localparam logic [127:0] DEN_ACC_Z   = 128'd5 * 128'(ACCEL_DEPTH);
   localparam logic [127:0] DEN_RATE_XY = 128'd1000000000 * 128'(RATE_DEPTH);
   localparam logic [127:0] DEN_RATE_Z  = 128'd12500000 * 128'(RATE_DEPTH);
   localparam logic [127:0] DEN_MAX     =
      (DEN_ACC_XY > DEN_RATE_XY) ? DEN_ACC_XY : DEN_RATE_XY;

   // Fraction bits: the coefficient is rounded up, and its error over the
   // whole magnitude range stays below half a step of the finest denominator,
   // so the truncated product lands on the exact rounded quotient.
   localparam int SCALE_FRAC = 1 + MAG_W + $clog2(DEN_MAX);
   localparam int COEF_W     = SCALE_FRAC + 8;
   localparam int HALF_W     = (COEF_W + 1) / 2;
   localparam int PP_W       = MAG_W + HALF_W;
   localparam int PROD_W     = MAG_W + 2 * HALF_W;
   localparam int FULL_W     = PROD_W + 1;
   localparam int QUO_W      = FULL_W - SCALE_FRAC;

   localparam logic [127:0] COEF_ACC_XY =
      ((128'd86620580697 << SCALE_FRAC) + DEN_ACC_XY - 128'd1) / DEN_ACC_XY;
   localparam logic [127:0] COEF_ACC_Z =
      ((128'd784 << SCALE_FRAC) + DEN_ACC_Z - 128'd1) / DEN_ACC_Z;
   localparam logic [127:0] COEF_RATE_XY =
      ((128'd24682682990 << SCALE_FRAC) + DEN_RATE_XY - 128'd1) / DEN_RATE_XY;
   localparam logic [127:0] COEF_RATE_Z =
      ((128'd436332313 << SCALE_FRAC) + DEN_RATE_Z - 128'd1) / DEN_RATE_Z;

   localparam logic [2*HALF_W-1:0] SCALE_COEF [LANES] = '{
      COEF_ACC_XY[2*HALF_W-1:0],
      COEF_ACC_XY[2*HALF_W-1:0],
      COEF_ACC_Z[2*HALF_W-1:0],
      COEF_RATE_XY[2*HALF_W-1:0],
      COEF_RATE_XY[2*HALF_W-1:0],
      COEF_RATE_Z[2*HALF_W-1:0]
   };

   localparam logic [FULL_W-1:0] ROUND_HALF = FULL_W'(1) << (SCALE_FRAC - 1);

   localparam logic [OUT_W-1:0] OUT_MAX   = 24'h7FFFFF;
   localparam logic [OUT_W-1:0] OUT_MIN   = 24'h800000;
   localparam logic [QUO_W-1:0] SAT_POS_Q = QUO_W'(24'h7FFFFF);
   localparam logic [QUO_W-1:0] SAT_NEG_Q = QUO_W'(25'h0800000);

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
   } imar_sample_type;

   typedef struct packed {
      logic signed [ACCEL_SUM_W-1:0] x;
      logic signed [ACCEL_SUM_W-1:0] y;
      logic signed [ACCEL_SUM_W-1:0] z;
   } imar_acc_sum_type;

   typedef struct packed {
      logic signed [RATE_SUM_W-1:0] x;
      logic signed [RATE_SUM_W-1:0] y;
      logic signed [RATE_SUM_W-1:0] z;
   } imar_rate_sum_type;

   // per-stage load strobes of the scaling pipeline
   typedef struct packed {
      logic load_b;
      logic load_c;
      logic load_d;
      logic load_e;
   } imar_adv_type;

endpackage

>>> rtl/imar_if.sv
// ----------------------------------------------------------------------------
// imar_req_if / imar_rsp_if
// Valid/ready channels for raw IMU sample words and filtered result words.
// ----------------------------------------------------------------------------
interface imar_req_if import imar_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] acc_x;
   logic signed [IN_W-1:0] acc_y;
   logic signed [IN_W-1:0] acc_z;
   logic signed [IN_W-1:0] rate_x;
   logic signed [IN_W-1:0] rate_y;
   logic signed [IN_W-1:0] rate_z;

   modport source (output valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                   input ready);
   modport sink (input valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                 output ready);
   modport monitor (input valid, ready, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z);
endinterface

interface imar_rsp_if import imar_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] accel_out_x;
   logic signed [OUT_W-1:0] accel_out_y;
   logic signed [OUT_W-1:0] accel_out_z;
   logic signed [OUT_W-1:0] rate_out_x;
   logic signed [OUT_W-1:0] rate_out_y;
   logic signed [OUT_W-1:0] rate_out_z;

   modport source (output valid, accel_out_x, accel_out_y, accel_out_z,
                   rate_out_x, rate_out_y, rate_out_z,
                   input ready);
   modport sink (input valid, accel_out_x, accel_out_y, accel_out_z,
                 rate_out_x, rate_out_y, rate_out_z,
                 output ready);
   modport monitor (input valid, ready, accel_out_x, accel_out_y, accel_out_z,
                    rate_out_x, rate_out_y, rate_out_z);
endinterface

>>> rtl/imu_moving_average_rotate.sv
// ----------------------------------------------------------------------------
// imu_moving_average_rotate
// Boxcar average of six-axis IMU samples with gyro offset removal, unit
// scaling, 45 degree rotation about z and Q7.16 saturation.
//
//   channel  dir  handshake      word
//   req_if   in   valid/ready    raw accel x/y/z, raw gyro x/y/z (16b signed)
//   rsp_if   out  valid/ready    accel_out x/y/z, rate_out x/y/z (24b Q7.16)
//   csr_*    in   write enable   gyro offsets x/y/z (16b signed), no read
//
// One word is accepted per cycle while req_if.ready is high; its result
// passes through the five register stages: window sums, rotation,
// partial products, rounding, saturation.
// Synchronous reset clears the window cells, the sums, the offsets and all
// valid flags.
// A stage holds only while it is full and the stage after it is blocked, so
// empty stages keep taking words while a result waits on rsp_if.
// ----------------------------------------------------------------------------
module imu_moving_average_rotate import imar_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   imar_req_if.sink              req_if,
   imar_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic signed [IN_W-1:0] gyro_off_x_ff;
   logic signed [IN_W-1:0] gyro_off_y_ff;
   logic signed [IN_W-1:0] gyro_off_z_ff;

   logic vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff, vld_e_ff;
   logic vld_a_in, vld_b_in, vld_c_in, vld_d_in, vld_e_in;
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
   logic accept;

   imar_sample_type             acc_smp;
   imar_sample_type             rate_smp;
   imar_acc_sum_type            acc_sum;
   imar_rate_sum_type           rate_sum;
   imar_adv_type                adv;
   logic [LANES-1:0][OUT_W-1:0] result;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_off_x_ff <= '0;
         gyro_off_y_ff <= '0;
         gyro_off_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GYRO_OFFSET_X: gyro_off_x_ff <= csr_wdata;
            CSR_GYRO_OFFSET_Y: gyro_off_y_ff <= csr_wdata;
            CSR_GYRO_OFFSET_Z: gyro_off_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage handshake: a stage takes a new word when empty or draining
   always_comb begin
      rdy_e = !vld_e_ff || rsp_if.ready;
      rdy_d = !vld_d_ff || rdy_e;
      rdy_c = !vld_c_ff || rdy_d;
      rdy_b = !vld_b_ff || rdy_c;
      rdy_a = !vld_a_ff || rdy_b;
      accept   = req_if.valid && rdy_a;
      vld_a_in = rdy_a ? req_if.valid : vld_a_ff;
      vld_b_in = rdy_b ? vld_a_ff     : vld_b_ff;
      vld_c_in = rdy_c ? vld_b_ff     : vld_c_ff;
      vld_d_in = rdy_d ? vld_c_ff     : vld_d_ff;
      vld_e_in = rdy_e ? vld_d_ff     : vld_e_ff;
      adv.load_b = rdy_b;
      adv.load_c = rdy_c;
      adv.load_d = rdy_d;
      adv.load_e = rdy_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         vld_e_ff <= 1'b0;
      end else begin
         vld_a_ff <= vld_a_in;
         vld_b_ff <= vld_b_in;
         vld_c_ff <= vld_c_in;
         vld_d_ff <= vld_d_in;
         vld_e_ff <= vld_e_in;
      end
   end

   // remove gyro zero-rate offset, wrapping to 16 bits
   always_comb begin
      acc_smp.x  = req_if.acc_x;
      acc_smp.y  = req_if.acc_y;
      acc_smp.z  = req_if.acc_z;
      rate_smp.x = req_if.rate_x - gyro_off_x_ff;
      rate_smp.y = req_if.rate_y - gyro_off_y_ff;
      rate_smp.z = req_if.rate_z - gyro_off_z_ff;
   end

   imar_window u_window (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .acc_smp  (acc_smp),
      .rate_smp (rate_smp),
      .acc_sum  (acc_sum),
      .rate_sum (rate_sum)
   );

   imar_scale u_scale (
      .clock    (clock),
      .adv      (adv),
      .acc_sum  (acc_sum),
      .rate_sum (rate_sum),
      .result   (result)
   );

   assign req_if.ready       = rdy_a;
   assign rsp_if.valid       = vld_e_ff;
   assign rsp_if.accel_out_x = result[LANE_ACC_X];
   assign rsp_if.accel_out_y = result[LANE_ACC_Y];
   assign rsp_if.accel_out_z = result[LANE_ACC_Z];
   assign rsp_if.rate_out_x  = result[LANE_RATE_X];
   assign rsp_if.rate_out_y  = result[LANE_RATE_Y];
   assign rsp_if.rate_out_z  = result[LANE_RATE_Z];

endmodule

>>> rtl/imar_cell.sv
// ----------------------------------------------------------------------------
// imar_cell
// One window entry: holds a three-axis sample and passes it to the next
// entry on every shift.
// ----------------------------------------------------------------------------
module imar_cell import imar_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            shift,
   input  imar_sample_type smp_in,
   output imar_sample_type smp_out
);

   imar_sample_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else if (shift) begin
         data_ff <= smp_in;
      end
   end

   assign smp_out = data_ff;

endmodule

>>> rtl/imar_window.sv
// ----------------------------------------------------------------------------
// imar_window
// Accelerometer and gyro sample windows as chains of cells, with running
// per-axis sums updated from the entering and the leaving sample.
// ----------------------------------------------------------------------------
module imar_window import imar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  imar_sample_type   acc_smp,
   input  imar_sample_type   rate_smp,
   output imar_acc_sum_type  acc_sum,
   output imar_rate_sum_type rate_sum
);

   imar_sample_type   acc_tap  [ACCEL_DEPTH+1];
   imar_sample_type   rate_tap [RATE_DEPTH+1];
   imar_acc_sum_type  acc_sum_ff,  acc_sum_in;
   imar_rate_sum_type rate_sum_ff, rate_sum_in;

   assign acc_tap[0]  = acc_smp;
   assign rate_tap[0] = rate_smp;

   for (genvar i = 0; i < ACCEL_DEPTH; i++) begin : g_acc_cell
      imar_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (load),
         .smp_in  (acc_tap[i]),
         .smp_out (acc_tap[i+1])
      );
   end

   for (genvar i = 0; i < RATE_DEPTH; i++) begin : g_rate_cell
      imar_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (load),
         .smp_in  (rate_tap[i]),
         .smp_out (rate_tap[i+1])
      );
   end

   // add the entering sample, drop the one falling off the end
   always_comb begin
      acc_sum_in.x = acc_sum_ff.x + ACCEL_SUM_W'(acc_smp.x)
                     - ACCEL_SUM_W'(acc_tap[ACCEL_DEPTH].x);
      acc_sum_in.y = acc_sum_ff.y + ACCEL_SUM_W'(acc_smp.y)
                     - ACCEL_SUM_W'(acc_tap[ACCEL_DEPTH].y);
      acc_sum_in.z = acc_sum_ff.z + ACCEL_SUM_W'(acc_smp.z)
                     - ACCEL_SUM_W'(acc_tap[ACCEL_DEPTH].z);
      rate_sum_in.x = rate_sum_ff.x + RATE_SUM_W'(rate_smp.x)
                      - RATE_SUM_W'(rate_tap[RATE_DEPTH].x);
      rate_sum_in.y = rate_sum_ff.y + RATE_SUM_W'(rate_smp.y)
                      - RATE_SUM_W'(rate_tap[RATE_DEPTH].y);
      rate_sum_in.z = rate_sum_ff.z + RATE_SUM_W'(rate_smp.z)
                      - RATE_SUM_W'(rate_tap[RATE_DEPTH].z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_sum_ff  <= '0;
         rate_sum_ff <= '0;
      end else if (load) begin
         acc_sum_ff  <= acc_sum_in;
         rate_sum_ff <= rate_sum_in;
      end
   end

   assign acc_sum  = acc_sum_ff;
   assign rate_sum = rate_sum_ff;

endmodule

>>> rtl/imar_scale.sv
// ----------------------------------------------------------------------------
// imar_scale
// Rotation, constant scaling with round-half-away rounding, and saturation
// of the six window means, in four register stages.
// ----------------------------------------------------------------------------
module imar_scale import imar_pkg::*; (
   input  logic                        clock,
   input  imar_adv_type                adv,
   input  imar_acc_sum_type            acc_sum,
   input  imar_rate_sum_type           rate_sum,
   output logic [LANES-1:0][OUT_W-1:0] result
);

   logic signed [MAG_W-1:0] lane_val  [LANES];
   logic                    sign_b_in [LANES];
   logic [MAG_W-1:0]        mag_b_in  [LANES];
   logic                    sign_b_ff [LANES];
   logic [MAG_W-1:0]        mag_b_ff  [LANES];
   logic                    sign_c_ff [LANES];
   logic [PP_W-1:0]         pp_lo_ff  [LANES];
   logic [PP_W-1:0]         pp_hi_ff  [LANES];
   logic [FULL_W-1:0]       full_d    [LANES];
   logic                    sign_d_ff [LANES];
   logic [QUO_W-1:0]        quo_d_ff  [LANES];
   logic [OUT_W-1:0]        res_e_in  [LANES];
   logic [OUT_W-1:0]        res_e_ff  [LANES];

   // rotate 45 degrees about z, negate z
   always_comb begin
      lane_val[LANE_ACC_X]  = MAG_W'(acc_sum.y) - MAG_W'(acc_sum.x);
      lane_val[LANE_ACC_Y]  = MAG_W'(acc_sum.x) + MAG_W'(acc_sum.y);
      lane_val[LANE_ACC_Z]  = -MAG_W'(acc_sum.z);
      lane_val[LANE_RATE_X] = MAG_W'(rate_sum.y) - MAG_W'(rate_sum.x);
      lane_val[LANE_RATE_Y] = MAG_W'(rate_sum.x) + MAG_W'(rate_sum.y);
      lane_val[LANE_RATE_Z] = -MAG_W'(rate_sum.z);
      for (int i = 0; i < LANES; i++) begin
         sign_b_in[i] = lane_val[i][MAG_W-1];
         mag_b_in[i]  = sign_b_in[i] ? MAG_W'(-lane_val[i]) : MAG_W'(lane_val[i]);
      end
   end

   // join partial products, add half a step, drop the fraction
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         full_d[i] = (FULL_W'(pp_hi_ff[i]) << HALF_W) + FULL_W'(pp_lo_ff[i]) + ROUND_HALF;
      end
   end

   // restore sign and clamp to the Q7.16 range
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (sign_d_ff[i]) begin
            res_e_in[i] = (quo_d_ff[i] > SAT_NEG_Q) ? OUT_MIN : -OUT_W'(quo_d_ff[i]);
         end else begin
            res_e_in[i] = (quo_d_ff[i] > SAT_POS_Q) ? OUT_MAX : OUT_W'(quo_d_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (adv.load_b) begin
            sign_b_ff[i] <= sign_b_in[i];
            mag_b_ff[i]  <= mag_b_in[i];
         end
         if (adv.load_c) begin
            sign_c_ff[i] <= sign_b_ff[i];
            pp_lo_ff[i]  <= PP_W'(mag_b_ff[i]) * PP_W'(SCALE_COEF[i][HALF_W-1:0]);
            pp_hi_ff[i]  <= PP_W'(mag_b_ff[i]) * PP_W'(SCALE_COEF[i][2*HALF_W-1:HALF_W]);
         end
         if (adv.load_d) begin
            sign_d_ff[i] <= sign_c_ff[i];
            quo_d_ff[i]  <= full_d[i][FULL_W-1:SCALE_FRAC];
         end
         if (adv.load_e) begin
            res_e_ff[i] <= res_e_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         result[i] = res_e_ff[i];
      end
   end

endmodule

>>> rtl/imar_checker.sv
// ----------------------------------------------------------------------------
// imar_checker
// Port-level checks of the IMU averager: reset, pipeline depth, stall
// behavior and result hold.
// ----------------------------------------------------------------------------
module imar_checker import imar_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [LANES-1:0][OUT_W-1:0] rsp_word
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // a free output never blocks the input side
   a_ready_path: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output side is ready");

   // no result can appear sooner than the pipeline depth after reset
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (!$past(reset, 1) && !$past(reset, 2)
                            && !$past(reset, 3) && !$past(reset, 4)))
      else $error("result word earlier than pipeline depth");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("result word changed while stalled");

endmodule

bind imu_moving_average_rotate imar_checker u_imar_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_word  ({rsp_if.rate_out_z, rsp_if.rate_out_y, rsp_if.rate_out_x,
                rsp_if.accel_out_z, rsp_if.accel_out_y, rsp_if.accel_out_x})
);
